### hw/rtl/gwb_pkg.sv
// shared types and constants for the gradient weighted binarizer
// used by the top level and checker
package gwb_pkg;

    localparam int CFG_DATA_BITS = 12;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_DATA_BITS-1:0] FRAME_WIDTH_RESET = 12'd640;
    localparam logic [CFG_DATA_BITS-1:0] FRAME_HEIGHT_RESET = 12'd480;

    localparam logic OP_GRADIENT = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_THRESHOLD = 1'b1;

    localparam logic [8:0] THRESHOLD_MAX = 9'd256;

    typedef struct packed {
        logic       operation;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic       kind;
        logic       pixel_bit;
        logic [8:0] threshold_value;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_ACC,
        ST_FLUSH,
        ST_DIVGO,
        ST_DIVWAIT
    } state_t;

endpackage

### hw/rtl/gwb_line_mem.sv
// two-row gray line buffer: one write port, two registered read ports
// no package dependency
module gwb_line_mem #(
    parameter int COL_BITS = 11
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [COL_BITS:0]   wr_addr,
    input  logic [7:0]          wr_data,
    input  logic [COL_BITS:0]   rd_addr_a,
    input  logic [COL_BITS:0]   rd_addr_b,
    output logic [7:0]          rd_data_a,
    output logic [7:0]          rd_data_b
);

    logic [7:0] mem [2**(COL_BITS+1)];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

### hw/rtl/gwb_div.sv
// restoring divider for the end-of-frame threshold, one quotient bit a cycle
// result is truncated toward zero and clamped to 0..256; no package dependency
module gwb_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [47:0] num,
    input  logic signed [31:0] den,
    output logic               busy,
    output logic [8:0]         quotient
);

    logic        busy_reg;
    logic [3:0]  cnt_reg;
    logic [47:0] rem_reg;
    logic [39:0] dsh_reg;
    logic [8:0]  q_reg;
    logic        fits;
    logic [47:0] num_mag;
    logic [31:0] den_mag;

    assign num_mag = num[47] ? 48'(-num) : 48'(num);
    assign den_mag = den[31] ? 32'(-den) : 32'(den);
    assign fits = rem_reg >= {8'b0, dsh_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= 4'd0;
            q_reg <= 9'd0;
        end
        else if (start)
        begin
            cnt_reg <= 4'd8;
            q_reg <= 9'd0;
            // zero divisor, zero dividend or negative quotient all give zero
            busy_reg <= !(den == 32'sd0 || num == 48'sd0 || num[47] != den[31]);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 4'd8)
            begin
                if (fits)
                begin
                    q_reg <= 9'd256;
                    busy_reg <= 1'b0;
                end
            end
            else
            begin
                q_reg <= {q_reg[7:0], fits};
                if (cnt_reg == 4'd0)
                begin
                    busy_reg <= 1'b0;
                end
            end
            cnt_reg <= cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num_mag;
            dsh_reg <= {den_mag, 8'b0};
        end
        else if (busy_reg)
        begin
            if (fits && cnt_reg != 4'd8)
            begin
                rem_reg <= rem_reg - {8'b0, dsh_reg};
            end
            dsh_reg <= {1'b0, dsh_reg[39:1]};
        end
    end

    assign busy = busy_reg;
    assign quotient = q_reg;

endmodule

### hw/rtl/gradient_weighted_binarizer_top.sv
// classify beat: result in the output register the cycle after it is accepted
// gradient beat: accept, two line buffer reads, three terms, write back
// last gradient beat adds the divider before the threshold beat
// rate is set by the shared term multiplier and the two-port line buffer
// reset clears counters, sums and threshold and loads the default frame size; the line buffer is not cleared
module gradient_weighted_binarizer_top #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 pixel_valid,
    output logic                                 pixel_stall,
    input  gwb_pkg::pixel_t                      pixel,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output gwb_pkg::result_t                     result,
    input  logic                                 cfg_write,
    input  logic [gwb_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [gwb_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
    localparam int HW = ($clog2(MAX_HEIGHT + 1) > 12) ? $clog2(MAX_HEIGHT + 1) : 12;

    gwb_pkg::state_t  state_reg, state_next;
    gwb_pkg::result_t result_reg;
    logic             result_valid_reg;
    logic [11:0]      frame_width_reg, frame_height_reg;
    logic [AW-1:0]    col_reg;
    logic [RW-1:0]    row_reg;
    logic [7:0]       gray_reg, cl1_reg, cl2_reg, p0_reg, pp1_reg;
    logic [1:0]       k_reg;
    logic signed [17:0] prod_reg;
    logic signed [8:0]  g_reg;
    logic signed [47:0] wsum_reg;
    logic signed [31:0] gsum_reg;
    logic [8:0]       thr_reg;

    logic [12:0]      gray_sum;
    logic [7:0]       gray_in;
    logic             out_free, accept;
    logic [WW-1:0]    fw_ext, eff_w;
    logic [HW-1:0]    fh_ext, eff_h;
    logic             last_col, last_row, first_col, second_row;
    logic [AW:0]      rd_addr_a, rd_addr_b, wr_addr;
    logic [7:0]       rd_data_a, rd_data_b;
    logic             mem_we, div_start, div_busy;
    logic [8:0]       div_q;
    logic [7:0]       term_v;
    logic signed [8:0] term_gx, term_gy, term_g;
    logic             term_en;
    logic             restart, cfg_hit;

    // gray conversion of the incoming beat
    assign gray_sum = 13'(11 * pixel.red) + 13'(16 * pixel.green) + 13'(5 * pixel.blue);
    assign gray_in = gray_sum[12:5];

    assign out_free = !result_valid_reg || !result_stall;
    assign pixel_stall = !(state_reg == gwb_pkg::ST_IDLE && out_free);
    assign accept = pixel_valid && !pixel_stall;

    // frame size saturated to the supported range
    assign fw_ext = WW'(frame_width_reg);
    assign fh_ext = HW'(frame_height_reg);
    always_comb
    begin
        if (fw_ext < WW'(2))
            eff_w = WW'(2);
        else if (fw_ext > WW'(MAX_WIDTH))
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = fw_ext;
        if (fh_ext < HW'(2))
            eff_h = HW'(2);
        else if (fh_ext > HW'(MAX_HEIGHT))
            eff_h = HW'(MAX_HEIGHT);
        else
            eff_h = fh_ext;
    end

    assign last_col = (WW'(col_reg) + WW'(1)) == eff_w;
    assign last_row = (HW'(row_reg) + HW'(1)) == eff_h;
    assign first_col = col_reg == '0;
    assign second_row = row_reg == RW'(1);

    // line buffer addressing: slot row[0] holds this row and the row two above
    always_comb
    begin
        if (state_reg == gwb_pkg::ST_RD0)
        begin
            rd_addr_a = {~row_reg[0], col_reg};
            rd_addr_b = {~row_reg[0], AW'(col_reg + AW'(1))};
        end
        else
        begin
            rd_addr_a = {~row_reg[0], AW'(col_reg - AW'(1))};
            rd_addr_b = {row_reg[0], col_reg};
        end
    end
    assign wr_addr = {row_reg[0], col_reg};
    assign mem_we = state_reg == gwb_pkg::ST_FLUSH;

    gwb_line_mem #(
        .COL_BITS(AW)
    ) u_mem (
        .clk       (clk),
        .wr_en     (mem_we),
        .wr_addr   (wr_addr),
        .wr_data   (gray_reg),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // gradient terms; in ST_ACC port a holds the pixel above-left, port b two rows up
    always_comb
    begin
        term_v = 8'd0;
        term_gx = 9'sd0;
        term_gy = 9'sd0;
        term_en = 1'b0;
        case (k_reg)
            2'd0:
            begin
                // pixel above is complete now
                term_en = row_reg != '0;
                term_v = p0_reg;
                if (first_col)
                    term_gx = $signed({1'b0, pp1_reg});
                else if (last_col)
                    term_gx = $signed({1'b0, rd_data_a});
                else
                    term_gx = $signed({1'b0, pp1_reg}) - $signed({1'b0, rd_data_a});
                if (second_row)
                    term_gy = $signed({1'b0, gray_reg});
                else
                    term_gy = $signed({1'b0, gray_reg}) - $signed({1'b0, rd_data_b});
            end
            2'd1:
            begin
                // last row: left neighbor is complete now
                term_en = last_row && !first_col;
                term_v = cl1_reg;
                if (col_reg == AW'(1))
                    term_gx = $signed({1'b0, gray_reg});
                else
                    term_gx = $signed({1'b0, gray_reg}) - $signed({1'b0, cl2_reg});
                term_gy = $signed({1'b0, rd_data_a});
            end
            default:
            begin
                // frame end: the pixel itself
                term_en = last_row && last_col;
                term_v = gray_reg;
                term_gx = $signed({1'b0, cl1_reg});
                term_gy = $signed({1'b0, p0_reg});
            end
        endcase
        term_g = (term_gx >= term_gy) ? term_gx : term_gy;
    end

    assign div_start = state_reg == gwb_pkg::ST_DIVGO;

    gwb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (wsum_reg),
        .den      (gsum_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gwb_pkg::ST_IDLE:
            begin
                if (accept && pixel.operation == gwb_pkg::OP_GRADIENT)
                    state_next = gwb_pkg::ST_RD0;
            end
            gwb_pkg::ST_RD0:
                state_next = gwb_pkg::ST_RD1;
            gwb_pkg::ST_RD1:
                state_next = gwb_pkg::ST_ACC;
            gwb_pkg::ST_ACC:
            begin
                if (k_reg == 2'd2)
                    state_next = gwb_pkg::ST_FLUSH;
            end
            gwb_pkg::ST_FLUSH:
            begin
                if (last_row && last_col)
                    state_next = gwb_pkg::ST_DIVGO;
                else
                    state_next = gwb_pkg::ST_IDLE;
            end
            gwb_pkg::ST_DIVGO:
                state_next = gwb_pkg::ST_DIVWAIT;
            gwb_pkg::ST_DIVWAIT:
            begin
                if (!div_busy && out_free)
                    state_next = gwb_pkg::ST_IDLE;
            end
            default:
                state_next = gwb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gwb_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign cfg_hit = cfg_write &&
        (cfg_index == gwb_pkg::CFG_FRAME_WIDTH || cfg_index == gwb_pkg::CFG_FRAME_HEIGHT);
    assign restart = cfg_hit ||
        (state_reg == gwb_pkg::ST_DIVWAIT && !div_busy && out_free);

    // control: config, counters, sums, threshold, output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= gwb_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= gwb_pkg::FRAME_HEIGHT_RESET;
            col_reg <= '0;
            row_reg <= '0;
            wsum_reg <= '0;
            gsum_reg <= '0;
            thr_reg <= '0;
            k_reg <= 2'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && cfg_index == gwb_pkg::CFG_FRAME_WIDTH)
                frame_width_reg <= cfg_data;
            if (cfg_write && cfg_index == gwb_pkg::CFG_FRAME_HEIGHT)
                frame_height_reg <= cfg_data;

            if (state_reg == gwb_pkg::ST_ACC)
                k_reg <= k_reg + 2'd1;
            else
                k_reg <= 2'd0;

            if (restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
                wsum_reg <= '0;
                gsum_reg <= '0;
            end
            else
            begin
                if ((state_reg == gwb_pkg::ST_ACC && k_reg != 2'd0) ||
                    state_reg == gwb_pkg::ST_FLUSH)
                begin
                    wsum_reg <= wsum_reg + 48'(prod_reg);
                    gsum_reg <= gsum_reg + 32'(g_reg);
                end
                if (state_reg == gwb_pkg::ST_FLUSH && !(last_row && last_col))
                begin
                    if (last_col)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + RW'(1);
                    end
                    else
                    begin
                        col_reg <= col_reg + AW'(1);
                    end
                end
            end

            if (state_reg == gwb_pkg::ST_DIVWAIT && !div_busy && out_free)
                thr_reg <= div_q;

            if (accept && pixel.operation == gwb_pkg::OP_CLASSIFY)
                result_valid_reg <= 1'b1;
            else if (state_reg == gwb_pkg::ST_DIVWAIT && !div_busy && out_free)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            gray_reg <= gray_in;
        // previous two gray values of the current row, shifted once a pixel is done
        if (state_reg == gwb_pkg::ST_FLUSH)
        begin
            cl1_reg <= gray_reg;
            cl2_reg <= cl1_reg;
        end
        if (state_reg == gwb_pkg::ST_RD1)
        begin
            p0_reg <= rd_data_a;
            pp1_reg <= rd_data_b;
        end
        if (state_reg == gwb_pkg::ST_ACC)
        begin
            prod_reg <= term_en ? 18'($signed({1'b0, term_v}) * term_g) : 18'sd0;
            g_reg <= term_en ? term_g : 9'sd0;
        end
        if (accept && pixel.operation == gwb_pkg::OP_CLASSIFY)
        begin
            result_reg.kind <= gwb_pkg::KIND_PIXEL;
            result_reg.pixel_bit <= {1'b0, gray_in} >= thr_reg;
            result_reg.threshold_value <= 9'd0;
        end
        else if (state_reg == gwb_pkg::ST_DIVWAIT && !div_busy && out_free)
        begin
            result_reg.kind <= gwb_pkg::KIND_THRESHOLD;
            result_reg.pixel_bit <= 1'b0;
            result_reg.threshold_value <= div_q;
        end
    end

    assign result_valid = result_valid_reg;
    assign result = result_reg;

endmodule

### hw/rtl/gwb_checker.sv
// port-level checks for the gradient weighted binarizer
// depends on gwb_pkg; bound to the top level below
module gwb_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               pixel_valid,
    input logic                               pixel_stall,
    input gwb_pkg::pixel_t                    pixel,
    input logic                               result_valid,
    input logic                               result_stall,
    input gwb_pkg::result_t                   result
);

    // held result beat stays put
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // a classify beat shows up as a pixel result in the next cycle
    a_classify_result: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_stall && pixel.operation == gwb_pkg::OP_CLASSIFY
        |=> result_valid && result.kind == gwb_pkg::KIND_PIXEL
            && result.threshold_value == 9'd0)
        else $error("classify beat produced no pixel result");

    // a gradient beat keeps the input stalled while it works
    a_gradient_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_stall && pixel.operation == gwb_pkg::OP_GRADIENT
        |=> pixel_stall)
        else $error("gradient beat did not hold off the input");

    // threshold beats are clamped and carry no pixel bit
    a_threshold_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == gwb_pkg::KIND_THRESHOLD
        |-> result.threshold_value <= gwb_pkg::THRESHOLD_MAX && !result.pixel_bit)
        else $error("threshold beat out of range");

endmodule

bind gradient_weighted_binarizer_top gwb_checker u_gwb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
